// ===== rtl/shell_sort_engine_macros.svh =====
// Assertion helpers for the shell sort engine.
// Both macros sample on posedge clk and are disabled while arst_n is low.
`ifndef SHELL_SORT_ENGINE_MACROS_SVH
`define SHELL_SORT_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
`define SSE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SSE_ASSERT(lbl, prop, msg)
`define SSE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/sse_pkg.sv =====
package sse_pkg;

	localparam int unsigned WORD_W = 32;
	// queue between front and back
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = 2;
	localparam int unsigned QCW    = 3;

	// one classified input word
	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic              last;
		logic              keep;  // 0: store was full, word is discarded
	} qent_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_PASS,
		ST_SCAN,
		ST_READ_I,
		ST_HOLD,
		ST_CHECK,
		ST_CMP,
		ST_PUT,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_OUT_WAIT
	} sort_state_t;

endpackage

// ===== rtl/sse_front.sv =====
module sse_front import sse_pkg::*; #(
	parameter int unsigned DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [WORD_W-1:0] s_tdata,
	input  logic              s_tlast,
	input  logic              q_full,
	output logic              push,
	output qent_t             push_ent
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [CW-1:0] count_q;
	logic          keep;

	assign keep     = (count_q < CW'(DEPTH));
	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	always_comb begin
		push_ent.value = s_tdata;
		push_ent.last  = s_tlast;
		push_ent.keep  = keep;
	end

	// words taken in the current run, saturating at DEPTH
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			if (s_tlast) begin
				count_q <= '0;
			end else if (keep) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

endmodule

// ===== rtl/sse_queue.sv =====
module sse_queue import sse_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t push_ent,
	output logic  full,
	output logic  valid,
	input  logic  pop,
	output qent_t head
);

	qent_t           ent_q [QDEPTH];
	logic [QAW-1:0]  wptr_q;
	logic [QAW-1:0]  rptr_q;
	logic [QCW-1:0]  count_q;

	assign full  = (count_q == QCW'(QDEPTH));
	assign valid = (count_q != '0);
	assign head  = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QAW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QAW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCW'(1);
				2'b01:   count_q <= count_q - QCW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/sse_back.sv =====
`include "shell_sort_engine_macros.svh"

module sse_back import sse_pkg::*; #(
	parameter int unsigned DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  qent_t             q_ent,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [WORD_W-1:0] m_tdata,
	output logic              m_tlast,
	output logic              m_tuser
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	sort_state_t state_q, state_d;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_data_q;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [WORD_W-1:0] wr_data;

	logic [CW-1:0] wcnt_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] gap_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] k_q;
	logic          ovf_q;

	logic [WORD_W-1:0] held_q;
	logic [WORD_W-1:0] out_data_q;
	logic              out_last_q;
	logic              out_drop_q;

	logic [CW-1:0] jm;
	logic [CW-1:0] n_load;
	logic [CW-1:0] k_next;
	logic          greater;

	assign jm      = j_q - gap_q;
	assign n_load  = wcnt_q + CW'(q_ent.keep);
	assign k_next  = k_q + CW'(1);
	assign greater = ($signed(rd_data_q) > $signed(held_q));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:     if (q_valid && q_ent.last) begin
				state_d = ST_PASS;
			end
			ST_PASS:     state_d = (gap_q == '0) ? ST_OUT_RD : ST_SCAN;
			ST_SCAN:     state_d = (i_q >= n_q) ? ST_PASS : ST_READ_I;
			ST_READ_I:   state_d = ST_HOLD;
			ST_HOLD:     state_d = ST_CHECK;
			ST_CHECK:    state_d = (j_q >= gap_q) ? ST_CMP : ST_PUT;
			ST_CMP:      state_d = greater ? ST_CHECK : ST_PUT;
			ST_PUT:      state_d = ST_SCAN;
			ST_OUT_RD:   state_d = ST_OUT_LD;
			ST_OUT_LD:   state_d = ST_OUT_WAIT;
			ST_OUT_WAIT: if (m_tready) begin
				state_d = (k_next == n_q) ? ST_LOAD : ST_OUT_RD;
			end
			default:     state_d = ST_LOAD;
		endcase
	end

	// memory port control
	always_comb begin
		pop     = 1'b0;
		wr_en   = 1'b0;
		wr_addr = j_q[AW-1:0];
		wr_data = held_q;
		rd_addr = i_q[AW-1:0];
		case (state_q)
			ST_LOAD: begin
				pop     = q_valid;
				wr_en   = q_valid && q_ent.keep;
				wr_addr = wcnt_q[AW-1:0];
				wr_data = q_ent.value;
			end
			ST_CHECK:  rd_addr = jm[AW-1:0];
			ST_CMP: begin
				wr_en   = greater;
				wr_data = rd_data_q;
			end
			ST_PUT:    wr_en = 1'b1;
			ST_OUT_RD: rd_addr = k_q[AW-1:0];
			default: begin
			end
		endcase
	end

	assign m_tvalid = (state_q == ST_OUT_WAIT);
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_drop_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_HOLD) begin
			held_q <= rd_data_q;
		end
		if (state_q == ST_OUT_LD) begin
			out_data_q <= rd_data_q;
			out_last_q <= (k_next == n_q);
			out_drop_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			wcnt_q  <= '0;
			n_q     <= '0;
			gap_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOAD: if (pop) begin
					if (q_ent.keep) begin
						wcnt_q <= wcnt_q + CW'(1);
					end else begin
						ovf_q <= 1'b1;
					end
					if (q_ent.last) begin
						n_q   <= n_load;
						gap_q <= n_load >> 1;
					end
				end
				ST_PASS: begin
					i_q <= gap_q;
					k_q <= '0;
				end
				ST_SCAN: if (i_q >= n_q) begin
					gap_q <= gap_q >> 1;
				end
				ST_HOLD: j_q <= i_q;
				ST_CMP:  if (greater) begin
					j_q <= jm;
				end
				ST_PUT:  i_q <= i_q + CW'(1);
				ST_OUT_WAIT: if (m_tready) begin
					k_q <= k_next;
					if (k_next == n_q) begin
						wcnt_q <= '0;
						ovf_q  <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	`SSE_ASSERT(a_shift_in_run, (state_q == ST_CMP || state_q == ST_PUT) |-> (j_q < n_q), "shift index beyond run")
	`SSE_ASSERT(a_cmp_above_gap, (state_q == ST_CMP) |-> (j_q >= gap_q), "compare below gap")
	`SSE_ASSERT_NEXT(a_last_starts_sort, pop && q_ent.last, state_q == ST_PASS, "end of run did not start sort")

endmodule

// ===== rtl/shell_sort_engine.sv =====
// Shell sort engine. Signed 32-bit words stream in on the s_ side; a word
// with s_tlast high closes a run. Up to DEPTH words per run are kept, later
// ones are discarded and the whole run is then flagged on m_tuser. After the
// closing word the run is sorted ascending in place (Shell sort, gaps n/2,
// n/4 ... 1, each pass a gapped insertion sort) and sent out on the m_ side,
// smallest first, with m_tlast on the final word. Loading stores one word
// per cycle while the queue holds words, set by the single write port of
// the element memory. Each compare in the sort needs one read of the
// memory's one registered read port. Each output word is read, loaded into
// the output register and then held until m_tready. A 4-word queue keeps
// accepting input words of the next run while the back end sorts or emits,
// so s_tready drops only when it fills.
module shell_sort_engine import sse_pkg::*; #(
	parameter int unsigned DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [WORD_W-1:0] s_tdata,   // [31:0] value
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [WORD_W-1:0] m_tdata,   // [31:0] sorted_value
	output logic              m_tlast,
	output logic              m_tuser    // [0] dropped
);

	logic  push;
	qent_t push_ent;
	logic  q_full;
	logic  q_valid;
	logic  pop;
	qent_t q_head;

	// front: take words, mark those that no longer fit
	sse_front #(
		.DEPTH (DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.push     (push),
		.push_ent (push_ent)
	);

	// decouples input from the sort/emit sequencer
	sse_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.full     (q_full),
		.valid    (q_valid),
		.pop      (pop),
		.head     (q_head)
	);

	// back: store, sort in place, emit
	sse_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ent    (q_head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
